### hw/rtl/ror_pkg.sv
// ----------------------------------------------------------------------------
// ror_pkg
// Shared types, constants and helpers for the in-order reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ror_pkg;

  // Width of a message id and of a body handle
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;

  // Number of reorder slots; the slot k places past the ring base stands for id expected_id + k
  localparam int WINDOW = 32;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Ids this far ahead or less count as future ids, the rest as old ids
  localparam int HALF_RANGE = 32768;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_HELD      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  // Input transaction
  typedef struct packed {
    logic [ID_W-1:0]     msg_id;
    logic [HANDLE_W-1:0] body_handle;
  } msg_t;

  // Result transaction
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     out_msg_id;
    logic [HANDLE_W-1:0] out_handle;
    logic                last;
  } res_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // Observation signals from the controller
  typedef struct packed {
    logic draining;
    logic base_valid;
  } ctrl_mon_t;

  // Physical slot of logical offset k, with base and k both below WINDOW
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= (SLOT_W+1)'(WINDOW)) begin
      sum = sum - (SLOT_W+1)'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ror_ram.sv
// ----------------------------------------------------------------------------
// ror_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ror_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ror_ctrl.sv
// ----------------------------------------------------------------------------
// ror_ctrl
// Reorder sequencer: classifies arriving ids, keeps slot valid bits and the
// ring base, drives the handle RAM and builds each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ror_ctrl
  import ror_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                msg_valid,
  output logic                     msg_stall,
  input  wire msg_t                msg,
  input  wire logic                out_free,
  output logic                     load,
  output res_t                     res_next,
  output logic                     ram_we,
  output logic [SLOT_W-1:0]        ram_waddr,
  output logic [HANDLE_W-1:0]      ram_wdata,
  output logic                     ram_re,
  output logic [SLOT_W-1:0]        ram_raddr,
  input  wire logic [HANDLE_W-1:0] ram_rdata,
  output ctrl_mon_t                mon
);

  state_t              state, state_next;
  logic [ID_W-1:0]     expected_id, expected_id_next;
  logic [SLOT_W-1:0]   base, base_next;
  logic [WINDOW-1:0]   slot_valid, slot_valid_next;

  logic [ID_W-1:0]     diff;
  logic [SLOT_W-1:0]   hold_addr;
  logic [SLOT_W-1:0]   next_addr;
  logic                next_held;
  logic                accept;

  // Ring addressing: offset of the arriving id and the slot after the base
  assign diff      = msg.msg_id - expected_id;
  assign hold_addr = slot_addr(base, diff[SLOT_W-1:0]);
  assign next_addr = slot_addr(base, SLOT_W'(1));
  assign next_held = slot_valid[next_addr];

  // Take a new transaction only when idle and the result register can load
  assign msg_stall = !((state == S_IDLE) && out_free);
  assign accept    = msg_valid && !msg_stall;

  assign mon.draining   = (state == S_DRAIN);
  assign mon.base_valid = slot_valid[base];

  // Next state, slot bookkeeping and result build
  always_comb begin
    state_next       = state;
    expected_id_next = expected_id;
    base_next        = base;
    slot_valid_next  = slot_valid;
    load             = 1'b0;
    res_next         = '{status: ST_DELIVERED, out_msg_id: msg.msg_id,
                         out_handle: msg.body_handle, last: 1'b1};
    ram_we           = 1'b0;
    ram_waddr        = hold_addr;
    ram_wdata        = msg.body_handle;
    ram_re           = 1'b0;
    ram_raddr        = next_addr;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          if (diff == '0) begin
            // In order: deliver, advance, start a burst if the successor is held
            res_next.status  = ST_DELIVERED;
            res_next.last    = !next_held;
            expected_id_next = expected_id + ID_W'(1);
            base_next        = next_addr;
            if (next_held) begin
              ram_re                     = 1'b1;
              slot_valid_next[next_addr] = 1'b0;
              state_next                 = S_DRAIN;
            end
          end else if (diff < ID_W'(WINDOW)) begin
            // Inside the window: hold it unless the slot is taken already
            if (slot_valid[hold_addr]) begin
              res_next.status = ST_DUPLICATE;
            end else begin
              res_next.status            = ST_HELD;
              ram_we                     = 1'b1;
              slot_valid_next[hold_addr] = 1'b1;
            end
          end else if (diff <= ID_W'(HALF_RANGE)) begin
            res_next.status = ST_BEYOND;
          end else begin
            res_next.status = ST_DUPLICATE;
          end
        end
      end

      S_DRAIN: begin
        // Deliver the held body that the RAM read port holds, then look one slot further
        res_next.status     = ST_DELIVERED;
        res_next.out_msg_id = expected_id;
        res_next.out_handle = ram_rdata;
        res_next.last       = !next_held;
        if (out_free) begin
          load             = 1'b1;
          expected_id_next = expected_id + ID_W'(1);
          base_next        = next_addr;
          if (next_held) begin
            ram_re                     = 1'b1;
            slot_valid_next[next_addr] = 1'b0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Expected id, ring base and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
      base        <= '0;
      slot_valid  <= '0;
    end else begin
      expected_id <= expected_id_next;
      base        <= base_next;
      slot_valid  <= slot_valid_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/in_order_reliable_reorder_top.sv
// ----------------------------------------------------------------------------
// in_order_reliable_reorder_top
// Delivers reliable messages strictly in id order from a reorder window.
// ----------------------------------------------------------------------------
// Each input transaction carries a 16-bit wrapping message id and a body
// handle. An id equal to the expected one is delivered at once, followed by
// every consecutively held successor; an id up to WINDOW-1 ahead is held in
// a slot; ids further ahead (up to half the id space) are dropped as beyond
// the window; older ids and repeats of held ids are dropped as duplicates.
// Every input yields one result with last set, except an in-order delivery
// that releases n held successors, which yields n+1 results, last on the
// final one. Throughput: one input per cycle for held, dropped and plain
// in-order messages while the result output is not stalled; during a burst
// no input is taken. The handle RAM paces the burst: it is read one slot
// ahead of each delivery, and its read port is registered.
// Slot valid bits reset at once, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module in_order_reliable_reorder_top
  import ror_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output logic      msg_stall,
  input  wire msg_t msg,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  logic                out_free;
  logic                load;
  res_t                res_next;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [HANDLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [HANDLE_W-1:0] ram_rdata;
  ctrl_mon_t           mon;

  // Result register can load when empty or being taken
  assign out_free = !res_valid || !res_stall;

  ror_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .out_free  (out_free),
    .load      (load),
    .res_next  (res_next),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .mon       (mon)
  );

  // Held body handles, one entry per ring slot
  ror_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (WINDOW)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: load a new transaction or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  // The slot at the ring base stands for the expected id and is never held
  a_base_empty: assert property (@(posedge clk) disable iff (rst)
    !mon.base_valid)
    else $error("slot at ring base is marked valid");

  // A pending non-final result means a burst is still in progress
  a_burst_open: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> mon.draining)
    else $error("non-final result pending outside a burst");

  // Only a delivery can be followed by further results
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != ST_DELIVERED)) |-> res.last)
    else $error("held or dropped message without last");

  // Every accepted message produces a result in the next cycle
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg_stall) |=> res_valid)
    else $error("accepted message produced no result");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the in-order reorder buffer.
// ----------------------------------------------------------------------------
// Drives message transactions into the block and checks every result against
// a local model of the reorder window: in-order delivery, held slots, gap-fill
// bursts, duplicates and beyond-window drops. A short table of directed
// transactions comes first. Random windows of shuffled ids follow, mixed with
// repeats, stale ids, far-ahead ids and lost ids, under three idling patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import ror_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PLAN = 14;
  localparam int PHASE_ITEMS = 134;
  localparam int TAIL_CYCLES = 50;

  typedef struct {
    msg_t m;
    bit   typed;
    res_t want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  msg_t msg = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Window model
  logic [ID_W-1:0]     exp_next_id;
  logic                held_valid[WINDOW];
  logic [HANDLE_W-1:0] held_handle[WINDOW];

  res_t burst_results[$];
  res_t due_results[$];
  res_t seen_results[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int          bad_count = 0;

  row_t plan [N_PLAN];

  in_order_reliable_reorder_top uut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the expected id and shift the window down by one slot
  function automatic void advance_window();
    exp_next_id = exp_next_id + ID_W'(1);
    for (int k = 0; k + 1 < WINDOW; k++) begin
      held_valid[k]  = held_valid[k + 1];
      held_handle[k] = held_handle[k + 1];
    end
    held_valid[WINDOW - 1] = 1'b0;
  endfunction

  // Compute the results one transaction causes; leave them in burst_results
  function automatic void predict_delivery(input msg_t m);
    logic [ID_W-1:0] ahead;
    res_t r;
    burst_results.delete();
    ahead = m.msg_id - exp_next_id;
    r = '{ST_DELIVERED, m.msg_id, m.body_handle, 1'b0};
    if (ahead == '0) begin
      burst_results.insert(burst_results.size(), r);
      advance_window();
      // drain every consecutive held successor
      while (held_valid[0]) begin
        r.status     = ST_DELIVERED;
        r.out_msg_id = exp_next_id;
        r.out_handle = held_handle[0];
        r.last       = 1'b0;
        burst_results.insert(burst_results.size(), r);
        advance_window();
      end
    end else if (ahead < ID_W'(WINDOW)) begin
      if (held_valid[ahead[SLOT_W-1:0]]) begin
        r.status = ST_DUPLICATE;
      end else begin
        held_valid[ahead[SLOT_W-1:0]]  = 1'b1;
        held_handle[ahead[SLOT_W-1:0]] = m.body_handle;
        r.status = ST_HELD;
      end
      burst_results.insert(burst_results.size(), r);
    end else if (ahead <= ID_W'(HALF_RANGE)) begin
      r.status = ST_BEYOND;
      burst_results.insert(burst_results.size(), r);
    end else begin
      r.status = ST_DUPLICATE;
      burst_results.insert(burst_results.size(), r);
    end
    // flag the final result of this transaction
    r = burst_results.pop_back();
    r.last = 1'b1;
    burst_results.insert(burst_results.size(), r);
  endfunction

  // Offer one transaction, hold it until accepted, then record what it causes
  task automatic send_msg(input msg_t m, input bit typed, input res_t want);
    while ($urandom_range(99) < gap_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= m;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    predict_delivery(m);
    if (typed) begin
      due_results.insert(due_results.size(), want);
    end else begin
      foreach (burst_results[i]) due_results.insert(due_results.size(), burst_results[i]);
    end
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Capture accepted results at the edge
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      seen_results.insert(seen_results.size(), res);
    end
  end

  // Compare captured results in order, once all edge activity has settled
  always @(negedge clk) begin
    res_t got;
    res_t want;
    while (seen_results.size() != 0) begin
      got = seen_results.pop_front();
      if (due_results.size() == 0) begin
        if (bad_count < 10) begin
          $display("unexpected result: status=%0d id=%h handle=%h last=%b",
                   got.status, got.out_msg_id, got.out_handle, got.last);
        end
        bad_count++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          if (bad_count < 10) begin
            $display("mismatch: expected status=%0d id=%h handle=%h last=%b",
                     want.status, want.out_msg_id, want.out_handle, want.last);
            $display("          got      status=%0d id=%h handle=%h last=%b",
                     got.status, got.out_msg_id, got.out_handle, got.last);
          end
          bad_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int              n;
    int              j;
    int              tmp;
    int              sent;
    int              off[WINDOW];
    bit              full;
    logic [ID_W-1:0] base;
    msg_t            m;

    exp_next_id = '0;
    for (int k = 0; k < WINDOW; k++) begin
      held_valid[k]  = 1'b0;
      held_handle[k] = '0;
    end

    // Directed transactions: extremes, every status, repeats and a short burst
    plan = '{
      '{'{16'h0000, 16'h0000}, 1'b1, '{ST_DELIVERED, 16'h0000, 16'h0000, 1'b1}},
      '{'{16'hFFFF, 16'hFFFF}, 1'b1, '{ST_DUPLICATE, 16'hFFFF, 16'hFFFF, 1'b1}},
      '{'{16'h8001, 16'h1234}, 1'b1, '{ST_BEYOND,    16'h8001, 16'h1234, 1'b1}},
      '{'{16'h8002, 16'h4321}, 1'b1, '{ST_DUPLICATE, 16'h8002, 16'h4321, 1'b1}},
      '{'{16'h0021, 16'h00FF}, 1'b1, '{ST_BEYOND,    16'h0021, 16'h00FF, 1'b1}},
      '{'{16'h0020, 16'hAAAA}, 1'b1, '{ST_HELD,      16'h0020, 16'hAAAA, 1'b1}},
      '{'{16'h0002, 16'h5555}, 1'b1, '{ST_HELD,      16'h0002, 16'h5555, 1'b1}},
      '{'{16'h0002, 16'h0F0F}, 1'b1, '{ST_DUPLICATE, 16'h0002, 16'h0F0F, 1'b1}},
      '{'{16'h0004, 16'h1111}, 1'b0, '0},
      '{'{16'h0003, 16'h2222}, 1'b0, '0},
      '{'{16'h0001, 16'h3333}, 1'b0, '0},
      '{'{16'h0001, 16'h7777}, 1'b1, '{ST_DUPLICATE, 16'h0001, 16'h7777, 1'b1}},
      '{'{16'h0005, 16'h8888}, 1'b1, '{ST_DELIVERED, 16'h0005, 16'h8888, 1'b1}},
      '{'{16'h0006, 16'h9999}, 1'b1, '{ST_DELIVERED, 16'h0006, 16'h9999, 1'b1}}
    };

    gap_pct   = 8;
    stall_pct <= 67;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_msg(plan[i].m, plan[i].typed, plan[i].want);

    // Random windows under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 8;
          stall_pct <= 67;
        end
        1: begin
          gap_pct   = 67;
          stall_pct <= 8;
        end
        default: begin
          gap_pct   = 0;
          stall_pct <= 0;
        end
      endcase
      sent = 0;
      full = 1'b1;
      while (sent < PHASE_ITEMS) begin
        base = exp_next_id;
        // pick a window span, mostly short
        if (full) begin
          n = WINDOW;
        end else begin
          tmp = $urandom_range(99);
          if (tmp < 70)      n = $urandom_range(1, 8);
          else if (tmp < 90) n = $urandom_range(9, WINDOW - 1);
          else               n = WINDOW;
        end
        // a full window sends the base id last to force the longest burst
        for (int k = 0; k < n; k++) off[k] = full ? (k + 1) % n : k;
        for (int k = (full ? n - 2 : n - 1); k > 0; k--) begin
          j      = $urandom_range(k);
          tmp    = off[k];
          off[k] = off[j];
          off[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
          // mix in repeats, stale ids, far-ahead ids and arbitrary ids
          if (!full && $urandom_range(99) < 12) begin
            case ($urandom_range(3))
              0:       m.msg_id = base + ID_W'($urandom_range(n - 1));
              1:       m.msg_id = base - ID_W'($urandom_range(1, HALF_RANGE - 1));
              2:       m.msg_id = base + ID_W'($urandom_range(WINDOW, HALF_RANGE));
              default: m.msg_id = ID_W'($urandom_range(65535));
            endcase
            m.body_handle = HANDLE_W'($urandom_range(65535));
            send_msg(m, 1'b0, '0);
            sent++;
          end
          // lose an id now and then so that later ones stay held
          if (!full && $urandom_range(99) < 4) continue;
          m.msg_id      = base + ID_W'(off[k]);
          m.body_handle = HANDLE_W'($urandom_range(65535));
          send_msg(m, 1'b0, '0);
          sent++;
        end
        full = 1'b0;
      end
    end
    msg_valid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (due_results.size() != 0 || seen_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

### in_order_reliable_reorder_top.f
hw/rtl/ror_pkg.sv
hw/rtl/ror_ram.sv
hw/rtl/ror_ctrl.sv
hw/rtl/in_order_reliable_reorder_top.sv
test/tb_top.sv
